// ===== rtl/clns_pkg.sv =====
// Shared types and constants for the character LCD nibble sequencer.
`default_nettype none

package clns_pkg;

	// request codes carried on the input tuser
	localparam logic [2:0] CMD_WR_CHAR  = 3'd0;
	localparam logic [2:0] CMD_WR_INSTR = 3'd1;
	localparam logic [2:0] CMD_INIT     = 3'd2;
	localparam logic [2:0] CMD_CLEAR    = 3'd3;
	localparam logic [2:0] CMD_CURSOR   = 3'd4;

	// display instructions
	localparam logic [7:0] INSTR_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] INSTR_DISP_OFF   = 8'h08;
	localparam logic [7:0] INSTR_CLEAR      = 8'h01;
	localparam logic [7:0] INSTR_DISP_ON    = 8'h0C;
	localparam logic [7:0] INSTR_HOME_ROW0  = 8'h80;
	localparam logic [7:0] INSTR_SLOW_LIMIT = 8'h04;

	// wake-up nibbles
	localparam logic [3:0] NIB_WAKE_8BIT = 4'h3;
	localparam logic [3:0] NIB_SET_4BIT  = 4'h2;

	// waits in microseconds
	localparam logic [14:0] WAIT_NONE     = 15'd0;
	localparam logic [14:0] WAIT_SLOW_US  = 15'd2000;
	localparam logic [14:0] WAIT_PWRUP_US = 15'd20000;
	localparam logic [14:0] WAIT_WAKE1_US = 15'd5000;
	localparam logic [14:0] WAIT_WAKE2_US = 15'd200;

	// event counts per request
	localparam logic [3:0] EV_BYTE  = 4'd2;
	localparam logic [3:0] EV_CLEAR = 4'd4;
	localparam logic [3:0] EV_INIT  = 4'd15;
	localparam logic [3:0] EV_NONE  = 4'd0;
	localparam logic [3:0] INIT_PRELUDE = 4'd5;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} clns_state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} clns_cmd_t;

	typedef struct packed {
		logic empty;
		logic final_ev;
		logic out_free;
	} clns_status_t;

	// instruction bytes sent after the wake-up prelude
	function automatic logic [7:0] init_byte(input logic [2:0] sel);
		logic [7:0] b;
		unique case (sel)
			3'd0: b = INSTR_FUNC_4BIT;
			3'd1: b = INSTR_DISP_OFF;
			3'd2: b = INSTR_CLEAR;
			3'd3: b = INSTR_DISP_ON;
			3'd4: b = INSTR_HOME_ROW0;
			default: b = INSTR_HOME_ROW0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Top level: character LCD 4-bit link sequencer, request in, bus events out.
// A taken request is latched; the run state then registers its first event in the output register.
// Throughput: one event per cycle while the output side takes them; the input
//   is held off until the last event of a request is emitted (15 events for initialise).
// Requests that give no events pass through the run state before the next one is accepted.
// Reset (arst_n low, asynchronous): controller idle, event index and output
//   valid cleared; payload registers are not reset.
`default_nettype none

module char_lcd_nibble_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // byte_value[7:0], row[9:8], column[15:10]
	input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
	// event side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // nibble[3:0], strobe_res[4], wait_us[19:5], 0[23:20]
	output logic [0:0]       m_axis_tuser,  // register_select[0]
	output logic             m_axis_tlast   // last event of the request's run
);
	import clns_pkg::*;

	clns_cmd_t    cmd;
	clns_status_t status;

	// controller: takes one request, then paces events into the output register
	clns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: holds the request, walks the event index, decodes each event
	clns_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_command (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_rs     (m_axis_tuser[0]),
		.out_last   (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/clns_dp.sv =====
// Datapath: request latch, event index, event decode and output register.
`default_nettype none

module clns_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire clns_pkg::clns_cmd_t   cmd,
	output clns_pkg::clns_status_t     status,
	input  wire logic [2:0]            in_command,
	input  wire logic [15:0]           in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [23:0]                out_data,
	output logic                       out_rs,
	output logic                       out_last
);
	import clns_pkg::*;

	logic [2:0]  cmd_q;
	logic [7:0]  bv_q;
	logic [1:0]  row_q;
	logic [5:0]  col_q;
	logic [3:0]  idx_q;

	logic        valid_q;
	logic        rs_q;
	logic [3:0]  nib_q;
	logic        strobe_q;
	logic [14:0] wait_q;
	logic        last_q;

	logic [3:0]  count;
	logic [3:0]  init_off;
	logic [7:0]  sel_byte;
	logic        low_half;
	logic        prelude;
	logic        ev_rs;
	logic [3:0]  ev_nib;
	logic        ev_strobe;
	logic [14:0] ev_wait;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			bv_q  <= in_data[7:0];
			row_q <= in_data[9:8];
			col_q <= in_data[15:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// events in this request
	always_comb begin
		unique case (cmd_q)
			CMD_WR_CHAR, CMD_WR_INSTR: count = EV_BYTE;
			CMD_INIT:                  count = EV_INIT;
			CMD_CLEAR:                 count = EV_CLEAR;
			CMD_CURSOR:                count = (!row_q[1] && col_q[5:4] == 2'b00) ?
			                                   EV_BYTE : EV_NONE;
			default:                   count = EV_NONE;
		endcase
	end

	// event decode for the current index
	always_comb begin
		init_off = idx_q - INIT_PRELUDE;
		prelude  = (cmd_q == CMD_INIT) && (idx_q < INIT_PRELUDE);
		low_half = idx_q[0];
		ev_rs    = (cmd_q == CMD_WR_CHAR);
		unique case (cmd_q)
			CMD_CURSOR: sel_byte = {1'b1, row_q[0], col_q};
			CMD_CLEAR:  sel_byte = idx_q[1] ? INSTR_HOME_ROW0 : INSTR_CLEAR;
			CMD_INIT: begin
				sel_byte = init_byte(init_off[3:1]);
				low_half = init_off[0];
			end
			default:    sel_byte = bv_q;
		endcase

		ev_nib    = low_half ? sel_byte[3:0] : sel_byte[7:4];
		ev_strobe = 1'b1;
		ev_wait   = (low_half && !ev_rs && sel_byte < INSTR_SLOW_LIMIT) ?
		            WAIT_SLOW_US : WAIT_NONE;

		if (prelude) begin
			unique case (idx_q[2:0])
				3'd0: begin
					ev_nib    = 4'h0;
					ev_strobe = 1'b0;
					ev_wait   = WAIT_PWRUP_US;
				end
				3'd1: begin
					ev_nib  = NIB_WAKE_8BIT;
					ev_wait = WAIT_WAKE1_US;
				end
				3'd2: begin
					ev_nib  = NIB_WAKE_8BIT;
					ev_wait = WAIT_WAKE2_US;
				end
				3'd3: begin
					ev_nib  = NIB_WAKE_8BIT;
					ev_wait = WAIT_NONE;
				end
				default: begin
					ev_nib  = NIB_SET_4BIT;
					ev_wait = WAIT_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rs_q     <= ev_rs;
			nib_q    <= ev_nib;
			strobe_q <= ev_strobe;
			wait_q   <= ev_wait;
			last_q   <= status.final_ev;
		end
	end

	always_comb begin
		status.empty    = (count == EV_NONE);
		status.final_ev = (idx_q == count - 4'd1);
		status.out_free = !valid_q || out_ready;
	end

	assign out_valid = valid_q;
	assign out_rs    = rs_q;
	assign out_last  = last_q;
	assign out_data  = {4'h0, wait_q, strobe_q, nib_q};

`ifndef ASSERT_OFF
	// the longest run has fifteen events, so index 15 is only reached after the last one
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> idx_q != 4'd15)
		else $error("event index out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data) &&
			$stable(out_rs) && $stable(out_last)))
		else $error("stalled event changed");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.empty)
		else $error("event emitted for a request with no events");
`endif

endmodule

`default_nettype wire

// ===== rtl/clns_ctrl.sv =====
// Controller: request intake and event pacing state machine.
`default_nettype none

module clns_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire clns_pkg::clns_status_t status,
	output clns_pkg::clns_cmd_t        cmd
);
	import clns_pkg::*;

	clns_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.empty) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.final_ev) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("event emitted into a full output register");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.final_ev) |=> state_q == ST_IDLE)
		else $error("controller did not return idle after final event");
	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN && !cmd.load))
		else $error("request load did not start a run");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_char_lcd_nibble_sequencer.sv =====
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;
	import clns_pkg::*;

	// cursor row 1 base address; row 0 uses INSTR_HOME_ROW0
	localparam logic [7:0] INSTR_ROW1_BASE = 8'hC0;
	localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
	localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
	localparam int TAIL_WAIT  = 20;    // settle time after the last event

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [5:0] column;
	} lcd_req_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic        strobe;
		logic [14:0] wait_us;
		logic        last;
	} bus_event_t;

	// pacing of the two sides; PH_HOLD stalls the event side once for HOLD_LEN
	typedef enum logic [2:0] {
		PH_NO_IDLE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH_IDLE,
		PH_HOLD
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [23:0] m_axis_tdata;
	wire  [0:0]  m_axis_tuser;
	wire         m_axis_tlast;

	lcd_req_t   pending[$];     // requests waiting to be offered
	bus_event_t events_due[$];  // predicted bus events, oldest first
	pace_t      pace = PH_NO_IDLE;
	int         errors = 0;
	int         hold_cycles = 0;
	int         idle_run = 0;
	lcd_req_t   offer;
	lcd_req_t   taken;
	bus_event_t got;
	bus_event_t want;

	char_lcd_nibble_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Expected-event generation
	// ------------------------------------------------------------------
	function automatic bus_event_t mk_event(logic rs, logic [3:0] nib, logic strobe,
			logic [14:0] wait_us);
		bus_event_t e;
		e.rs      = rs;
		e.nibble  = nib;
		e.strobe  = strobe;
		e.wait_us = wait_us;
		e.last    = 1'b0;
		return e;
	endfunction

	// a byte goes out high nibble first; clear/home-class instructions need a long wait
	function automatic void add_byte(ref bus_event_t seq[$], input logic [7:0] b,
			input logic rs);
		logic slow;
		slow = (rs == 1'b0) && (b < INSTR_SLOW_LIMIT);
		seq.push_back(mk_event(rs, b[7:4], 1'b1, WAIT_NONE));
		seq.push_back(mk_event(rs, b[3:0], 1'b1, slow ? WAIT_SLOW_US : WAIT_NONE));
	endfunction

	// work out the bus events of one request and queue them, last one flagged
	function automatic void predict_lcd_events(lcd_req_t req);
		bus_event_t seq[$];
		bus_event_t e;
		case (req.cmd)
			CMD_WR_CHAR:  add_byte(seq, req.byte_value, 1'b1);
			CMD_WR_INSTR: add_byte(seq, req.byte_value, 1'b0);
			CMD_INIT: begin
				// power-up wait, 8-bit wake-up three times, then switch to 4-bit
				seq.push_back(mk_event(1'b0, 4'h0, 1'b0, WAIT_PWRUP_US));
				seq.push_back(mk_event(1'b0, NIB_WAKE_8BIT, 1'b1, WAIT_WAKE1_US));
				seq.push_back(mk_event(1'b0, NIB_WAKE_8BIT, 1'b1, WAIT_WAKE2_US));
				seq.push_back(mk_event(1'b0, NIB_WAKE_8BIT, 1'b1, WAIT_NONE));
				seq.push_back(mk_event(1'b0, NIB_SET_4BIT, 1'b1, WAIT_NONE));
				add_byte(seq, INSTR_FUNC_4BIT, 1'b0);
				add_byte(seq, INSTR_DISP_OFF, 1'b0);
				add_byte(seq, INSTR_CLEAR, 1'b0);
				add_byte(seq, INSTR_DISP_ON, 1'b0);
				add_byte(seq, INSTR_HOME_ROW0, 1'b0);
			end
			CMD_CLEAR: begin
				add_byte(seq, INSTR_CLEAR, 1'b0);
				add_byte(seq, INSTR_HOME_ROW0, 1'b0);
			end
			CMD_CURSOR: begin
				// out-of-range row or column produces nothing
				if (req.row <= 2'd1 && req.column <= 6'd15)
					add_byte(seq, (req.row[0] ? INSTR_ROW1_BASE : INSTR_HOME_ROW0)
						| {2'b00, req.column}, 1'b0);
			end
			default: ; // unknown codes produce nothing
		endcase
		for (int i = 0; i < seq.size(); i++) begin
			e = seq[i];
			e.last = (i == seq.size() - 1);
			events_due.push_back(e);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic lcd_req_t mk_req(logic [2:0] cmd, logic [7:0] bv, logic [1:0] row,
			logic [5:0] column);
		lcd_req_t r;
		r.cmd        = cmd;
		r.byte_value = bv;
		r.row        = row;
		r.column     = column;
		return r;
	endfunction

	function automatic logic req_ignored(lcd_req_t r);
		return (r.cmd > CMD_CURSOR) ||
			(r.cmd == CMD_CURSOR && (r.row > 2'd1 || r.column > 6'd15));
	endfunction

	// mostly well-formed requests; unused fields still get random content
	function automatic lcd_req_t random_req();
		lcd_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r = mk_req(CMD_WR_CHAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
			6'($urandom_range(0, 63)));
		if (pick < 28) begin
			r.cmd = CMD_WR_CHAR;
		end else if (pick < 52) begin
			r.cmd = CMD_WR_INSTR;
			// favor the slow instructions and the boundary around them
			if ($urandom_range(0, 3) == 0)
				r.byte_value = 8'($urandom_range(0, 7));
		end else if (pick < 60) begin
			r.cmd = CMD_INIT;
		end else if (pick < 68) begin
			r.cmd = CMD_CLEAR;
		end else if (pick < 93) begin
			r.cmd = CMD_CURSOR;
			if ($urandom_range(0, 4) != 0) begin
				r.row    = 2'($urandom_range(0, 1));
				r.column = 6'($urandom_range(0, 15));
			end
		end else begin
			r.cmd = CMD_CURSOR + 3'($urandom_range(1, 3));
		end
		return r;
	endfunction

	// queue random requests until n of them actually produce events
	task automatic add_random(int n);
		lcd_req_t r;
		int counted;
		counted = 0;
		while (counted < n) begin
			r = random_req();
			pending.push_back(r);
			if (!req_ignored(r))
				counted++;
		end
	endtask

	// sender pause: wait until everything offered has been taken and answered
	task automatic drain();
		@(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || events_due.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: offers queued requests, predicts on each handshake
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken.cmd        = s_axis_tuser;
				taken.byte_value = s_axis_tdata[7:0];
				taken.row        = s_axis_tdata[9:8];
				taken.column     = s_axis_tdata[15:10];
				predict_lcd_events(taken);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= (pace == PH_SEND_IDLE ? 79 :
						pace == PH_BOTH_IDLE ? 7 : 0)) begin
					offer = pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {offer.column, offer.row, offer.byte_value};
					s_axis_tuser  <= offer.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Event monitor: checks each accepted event, paces m_axis_tready
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.rs      = m_axis_tuser[0];
				got.nibble  = m_axis_tdata[3:0];
				got.strobe  = m_axis_tdata[4];
				got.wait_us = m_axis_tdata[19:5];
				got.last    = m_axis_tlast;
				if (events_due.size() == 0) begin
					$error("unexpected event: rs=%0d nibble=%h strobe=%0d wait_us=%0d last=%0d",
						got.rs, got.nibble, got.strobe, got.wait_us, got.last);
					errors++;
				end else begin
					want = events_due.pop_front();
					if (got.rs !== want.rs) begin
						$error("register_select: expected %0d, got %0d", want.rs, got.rs);
						errors++;
					end
					if (got.nibble !== want.nibble) begin
						$error("nibble: expected %h, got %h", want.nibble, got.nibble);
						errors++;
					end
					if (got.strobe !== want.strobe) begin
						$error("strobe_res: expected %0d, got %0d", want.strobe, got.strobe);
						errors++;
					end
					if (got.wait_us !== want.wait_us) begin
						$error("wait_us: expected %0d, got %0d", want.wait_us, got.wait_us);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
				end
			end
			// one long hold-off so the block backs up into its request side
			if (pace == PH_HOLD && hold_cycles < HOLD_LEN) begin
				hold_cycles <= hold_cycles + 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(0, 99) >= (pace == PH_RECV_STALL ? 79 :
					pace == PH_BOTH_IDLE ? 7 : 0);
			end
		end
	end

	// watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every command, slow-instruction boundary,
		// cursor corners and out-of-range cursor, unknown codes
		pending.push_back(mk_req(CMD_WR_CHAR,  8'h00, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_WR_CHAR,  8'hFF, 2'd3, 6'd63));
		pending.push_back(mk_req(CMD_WR_CHAR,  8'hA5, 2'd1, 6'd42));
		pending.push_back(mk_req(CMD_WR_INSTR, 8'h00, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_WR_INSTR, 8'h03, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_WR_INSTR, 8'h04, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_WR_INSTR, 8'hFF, 2'd3, 6'd63));
		pending.push_back(mk_req(CMD_WR_INSTR, 8'h5A, 2'd2, 6'd21));
		pending.push_back(mk_req(CMD_INIT,     8'hFF, 2'd3, 6'd63));
		pending.push_back(mk_req(CMD_CLEAR,    8'h00, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd0, 6'd0));
		pending.push_back(mk_req(CMD_CURSOR,   8'hFF, 2'd0, 6'd15));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd1, 6'd0));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd1, 6'd15));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd2, 6'd0));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd3, 6'd5));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd0, 6'd16));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd1, 6'd63));
		pending.push_back(mk_req(CMD_CURSOR,   8'h00, 2'd3, 6'd63));
		pending.push_back(mk_req(CMD_CURSOR + 3'd1, 8'h55, 2'd1, 6'd7));
		pending.push_back(mk_req(CMD_CURSOR + 3'd2, 8'hAA, 2'd2, 6'd33));
		pending.push_back(mk_req(CMD_CURSOR + 3'd3, 8'hFF, 2'd3, 6'd63));
		pending.push_back(mk_req(CMD_INIT,     8'h00, 2'd0, 6'd0));
		drain();

		// back-pressure: receiver holds off while requests keep coming
		pace = PH_HOLD;
		add_random(30);
		drain();

		pace = PH_NO_IDLE;
		add_random(71);
		drain();

		pace = PH_SEND_IDLE;
		add_random(71);
		drain();

		pace = PH_RECV_STALL;
		add_random(71);
		drain();

		pace = PH_BOTH_IDLE;
		add_random(71);
		drain();

		// catch any stray event after the last expected one
		repeat (TAIL_WAIT) @(negedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
